// File: hdl/avpp_pkg.sv
// ----------------------------------------------------------------------------
// Voice priority planner package
// Shared record type, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package avpp_pkg;

  // Default number of stored sources per scene.
  localparam int MaxSourcesDefault = 64;
  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 4;
  // Scores at or below this value end the selection.
  localparam logic [31:0] ScoreFloor = 32'd65;
  // Numerator of the attenuation divide: 2^15 * 65536000.
  localparam logic [40:0] AttNum = 41'd2147483648000;

  // One classified source as handed from front to back.
  typedef struct packed {
    logic [31:0] id;
    logic        looping;
    logic [15:0] gain;
    logic [14:0] low_pass;
    logic [15:0] reverb;
    logic [31:0] score;
    logic        last;
  } rec_t;

  // Voice budget for each quality level.
  function automatic logic [6:0] budget_of(input logic [1:0] q);
    logic [6:0] b;
    case (q)
      2'd0:    b = 7'd24;
      2'd1:    b = 7'd36;
      2'd2:    b = 7'd48;
      default: b = 7'd64;
    endcase
    return b;
  endfunction

  // Kind boost in tenths.
  function automatic logic [6:0] boost_of(input logic [2:0] k);
    logic [6:0] b;
    case (k)
      3'd0:    b = 7'd40;
      3'd1:    b = 7'd38;
      3'd2:    b = 7'd34;
      3'd3:    b = 7'd25;
      3'd4:    b = 7'd21;
      3'd5:    b = 7'd15;
      3'd6:    b = 7'd12;
      default: b = 7'd16;
    endcase
    return b;
  endfunction

  // Exact floor(n / 10) for any 32-bit n by reciprocal multiplication.
  function automatic logic [31:0] div10(input logic [31:0] n);
    logic [63:0] p;
    p = 64'(n) * 64'h0_CCCC_CCCD;
    return 32'(p >> 35);
  endfunction

  // Exact floor(n / 100) for any 32-bit n by reciprocal multiplication.
  function automatic logic [31:0] div100(input logic [31:0] n);
    logic [63:0] p;
    p = 64'(n) * 64'h0_51EB_851F;
    return 32'(p >> 37);
  endfunction

endpackage

// File: hdl/avpp_front.sv
// ----------------------------------------------------------------------------
// Voice priority planner front end
// Accepts one source, runs the attenuation divide and the gain, filter,
// reverb and score arithmetic as a sequencer, then queues the record.
// ----------------------------------------------------------------------------
module avpp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        source_id,
  input  logic [2:0]         source_kind,
  input  logic               is_critical,
  input  logic               is_looping,
  input  logic signed [15:0] base_gain,
  input  logic signed [15:0] occlusion,
  input  logic signed [23:0] distance,
  input  logic signed [15:0] importance,
  input  logic signed [15:0] reverb_zone_send,
  input  logic               last_source,
  output logic               q_valid,
  input  logic               q_ready,
  output avpp_pkg::rec_t     q_data
);
  import avpp_pkg::*;

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_SQ   = 4'd1;
  localparam logic [3:0] F_DEN  = 4'd2;
  localparam logic [3:0] F_DIV  = 4'd3;
  localparam logic [3:0] F_M1   = 4'd4;
  localparam logic [3:0] F_M2   = 4'd5;
  localparam logic [3:0] F_M3   = 4'd6;
  localparam logic [3:0] F_M4   = 4'd7;
  localparam logic [3:0] F_M5   = 4'd8;
  localparam logic [3:0] F_PUSH = 4'd9;

  logic [3:0]         state;
  logic [31:0]        id_r;
  logic [2:0]         kind_r;
  logic               crit_r;
  logic               loop_r;
  logic               last_r;
  logic signed [15:0] bg_r;
  logic signed [15:0] oc_r;
  logic signed [23:0] dist_r;
  logic signed [15:0] imp_r;
  logic signed [15:0] rz_r;

  logic [45:0] dsq;
  logic [37:0] lin;
  logic [65:0] dsh;
  logic [40:0] rem;
  logic [3:0]  div_cnt;
  logic [15:0] att;
  logic [29:0] p1;
  logic [15:0] g1;
  logic [15:0] o6;
  logic [15:0] o11;
  logic [31:0] x1;
  logic [31:0] x2;
  logic [15:0] mix;
  logic [15:0] g2;
  logic [15:0] rvo;
  logic [14:0] lp;
  logic [31:0] q10;
  logic [31:0] score;

  // Clamped operands.
  logic [22:0] d_c;
  logic [14:0] o_c;
  logic [14:0] gp_c;
  logic [15:0] bgc_c;
  logic [14:0] imp_c;
  logic [15:0] rv_c;
  logic [6:0]  boost;
  logic [50:0] den;
  logic [3:0]  r10;
  logic [36:0] s_full;
  logic [32:0] s_sh;

  always_comb begin
    d_c   = dist_r[23] ? 23'd0 : dist_r[22:0];
    if (oc_r[15]) begin
      o_c = 15'd0;
    end else if (oc_r > 16'sd16384) begin
      o_c = 15'd16384;
    end else begin
      o_c = oc_r[14:0];
    end
    gp_c  = bg_r[15] ? 15'd0 : bg_r[14:0];
    if (bg_r[15]) begin
      bgc_c = 16'd0;
    end else if (bg_r > 16'sd4096) begin
      bgc_c = 16'd32768;
    end else begin
      bgc_c = {bg_r[12:0], 3'd0};
    end
    imp_c = imp_r[15] ? 15'd0 : imp_r[14:0];
    if (rz_r[15]) begin
      rv_c = 16'd0;
    end else if (rz_r > 16'sd16384) begin
      rv_c = 16'd32768;
    end else begin
      rv_c = {rz_r[14:0], 1'b0};
    end
    boost  = boost_of(kind_r) + (crit_r ? 7'd40 : 7'd0);
    den    = 51'd65536000 + 51'(lin) + 51'({dsq, 4'd0}) + 51'({dsq, 1'b0});
    r10    = 4'(x2 - 32'(q10 * 32'd10));
    s_full = 37'(q10) * 37'(boost)
           + 37'((18'(r10) * 18'(boost) * 18'd205) >> 11);
    s_sh   = 33'(s_full >> 4);
  end

  assign in_ready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);
  assign q_data   = '{id: id_r, looping: loop_r, gain: g2, low_pass: lp, reverb: rvo,
                      score: score, last: last_r};

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      div_cnt <= 4'd0;
    end else begin
      case (state)
        F_IDLE: if (in_valid) state <= F_SQ;
        F_SQ:   state <= F_DEN;
        F_DEN: begin
          state   <= F_DIV;
          div_cnt <= 4'd0;
        end
        F_DIV: begin
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) state <= F_M1;
        end
        F_M1:   state <= F_M2;
        F_M2:   state <= F_M3;
        F_M3:   state <= F_M4;
        F_M4:   state <= F_M5;
        F_M5:   state <= F_PUSH;
        F_PUSH: if (q_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath, one multiply group per step.
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          id_r   <= source_id;
          kind_r <= source_kind;
          crit_r <= is_critical;
          loop_r <= is_looping;
          last_r <= last_source;
          bg_r   <= base_gain;
          oc_r   <= occlusion;
          dist_r <= distance;
          imp_r  <= importance;
          rz_r   <= reverb_zone_send;
        end
      end
      F_SQ: begin
        dsq <= 46'(d_c) * 46'(d_c);
        lin <= 38'(d_c) * 38'd21760;
      end
      F_DEN: begin
        dsh <= {den, 15'd0};
        rem <= AttNum;
      end
      F_DIV: begin
        // Restoring divide, one quotient bit per cycle.
        if ({25'd0, rem} >= dsh) begin
          rem <= rem - dsh[40:0];
          att <= {att[14:0], 1'b1};
        end else begin
          att <= {att[14:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      F_M1: begin
        p1  <= 30'(imp_c) * 30'(gp_c);
        g1  <= 16'((32'(bgc_c) * 32'(att)) >> 15);
        o6  <= 16'(div10(32'(o_c) * 32'd6));
        o11 <= 16'(div10(32'(o_c) * 32'd11));
        lp  <= 15'((32'd327680000 - 32'(o_c) * 32'd17800) >> 14);
      end
      F_M2: begin
        x1  <= 32'((46'(p1) * 46'(att)) >> 15);
        g2  <= 16'((32'(g1) * 32'(17'd32768 - 17'(o11))) >> 15);
        mix <= 16'(div100(32'd1146880 + 32'(att) * 32'd65));
      end
      F_M3: begin
        x2  <= 32'((48'(x1) * 48'(17'd32768 - 17'(o6))) >> 15);
        rvo <= 16'((32'(rv_c) * 32'(mix)) >> 15);
      end
      F_M4: q10 <= div10(x2);
      F_M5: score <= s_sh[32] ? 32'hFFFF_FFFF : s_sh[31:0];
      default: ;
    endcase
  end

endmodule

// File: hdl/avpp_queue.sv
// ----------------------------------------------------------------------------
// Voice priority planner record queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module avpp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  avpp_pkg::rec_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output avpp_pkg::rec_t rd_data
);
  import avpp_pkg::*;

  localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);

  rec_t          slots [QueueDepth];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;

  assign wr_ready = (fill != CW'(QueueDepth));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QueueDepth - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(QueueDepth - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_data;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(QueueDepth))
    else $error("queue fill level out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wptr == rptr))
    else $error("empty queue with unequal pointers");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (fill == CW'(QueueDepth)) |=> (fill != '0) || $past(pop))
    else $error("full queue lost its contents");

endmodule

// File: hdl/avpp_back.sv
// ----------------------------------------------------------------------------
// Voice priority planner back end
// Stores classified sources, picks voices by repeated score scans and
// emits one decision per stored source in input order.
// ----------------------------------------------------------------------------
module avpp_back #(
  parameter int MAX_SOURCES = avpp_pkg::MaxSourcesDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     quality,
  input  logic           q_valid,
  output logic           q_ready,
  input  avpp_pkg::rec_t q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    decision_id,
  output logic           audible,
  output logic           virtualized,
  output logic [15:0]    voice_gain,
  output logic [14:0]    low_pass_hz,
  output logic [15:0]    reverb_send,
  output logic [5:0]     priority_rank,
  output logic           last_decision
);
  import avpp_pkg::*;

  localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = $clog2(MAX_SOURCES + 1);

  localparam logic [1:0] B_LOAD = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_RD   = 2'd2;
  localparam logic [1:0] B_EMIT = 2'd3;

  logic [1:0]  state;
  logic [CW-1:0] count;
  logic [CW-1:0] budget;
  logic [CW-1:0] rk;
  logic [CW-1:0] scan_addr;
  logic [CW-1:0] oaddr;
  logic          cmp_v;
  logic [IW-1:0] cmp_idx;
  logic          found;
  logic [31:0]   best;
  logic [IW-1:0] best_idx;
  logic [MAX_SOURCES-1:0] chosen;

  // Source memories.
  logic [31:0] id_mem    [MAX_SOURCES];
  logic        loop_mem  [MAX_SOURCES];
  logic [15:0] gain_mem  [MAX_SOURCES];
  logic [14:0] lp_mem    [MAX_SOURCES];
  logic [15:0] rv_mem    [MAX_SOURCES];
  logic [31:0] score_mem [MAX_SOURCES];
  logic [5:0]  rank_mem  [MAX_SOURCES];

  logic [31:0] id_rd;
  logic        loop_rd;
  logic [15:0] gain_rd;
  logic [14:0] lp_rd;
  logic [15:0] rv_rd;
  logic [31:0] score_rd;
  logic [5:0]  rank_rd;

  logic          pop;
  logic          store;
  logic [CW-1:0] cnt_after;
  logic [CW-1:0] bud_min;
  logic [IW-1:0] rd_addr;
  logic          issue;
  logic          scan_done;
  logic          pick;
  logic          slot_free;
  logic          better;

  always_comb begin
    pop       = (state == B_LOAD) && q_valid;
    store     = pop && (count < CW'(MAX_SOURCES));
    cnt_after = store ? count + 1'b1 : count;
    if (32'(budget_of(quality)) > 32'(cnt_after)) begin
      bud_min = cnt_after;
    end else begin
      bud_min = CW'(budget_of(quality));
    end
    issue     = (state == B_SCAN) && (scan_addr < count);
    scan_done = (state == B_SCAN) && !issue && !cmp_v;
    pick      = scan_done && found && (best > ScoreFloor);
    better    = cmp_v && !chosen[cmp_idx] && (!found || (score_rd > best));
    rd_addr   = (state == B_SCAN) ? scan_addr[IW-1:0] : oaddr[IW-1:0];
    slot_free = !out_valid || out_ready;
  end

  assign q_ready = (state == B_LOAD);

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (store) begin
      id_mem[count[IW-1:0]]    <= q_data.id;
      loop_mem[count[IW-1:0]]  <= q_data.looping;
      gain_mem[count[IW-1:0]]  <= q_data.gain;
      lp_mem[count[IW-1:0]]    <= q_data.low_pass;
      rv_mem[count[IW-1:0]]    <= q_data.reverb;
      score_mem[count[IW-1:0]] <= q_data.score;
    end
    if (pick) rank_mem[best_idx] <= 6'(rk);
    id_rd    <= id_mem[rd_addr];
    loop_rd  <= loop_mem[rd_addr];
    gain_rd  <= gain_mem[rd_addr];
    lp_rd    <= lp_mem[rd_addr];
    rv_rd    <= rv_mem[rd_addr];
    score_rd <= score_mem[rd_addr];
    rank_rd  <= rank_mem[rd_addr];
  end

  // Scan bookkeeping: best unpicked score, lowest index on ties.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_addr[IW-1:0];
    if (better) begin
      best     <= score_rd;
      best_idx <= cmp_idx;
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_LOAD;
      count     <= '0;
      budget    <= '0;
      rk        <= '0;
      scan_addr <= '0;
      oaddr     <= '0;
      cmp_v     <= 1'b0;
      found     <= 1'b0;
      chosen    <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new decision fills the output slot; a taken one empties it.
      if (state == B_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_LOAD: begin
          if (store) chosen[count[IW-1:0]] <= 1'b0;
          if (pop) begin
            count <= cnt_after;
            if (q_data.last) begin
              budget    <= bud_min;
              rk        <= '0;
              scan_addr <= '0;
              cmp_v     <= 1'b0;
              found     <= 1'b0;
              state     <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          cmp_v <= issue;
          if (issue) scan_addr <= scan_addr + 1'b1;
          if (better) found <= 1'b1;
          if (scan_done) begin
            if (pick) chosen[best_idx] <= 1'b1;
            if (pick && (rk + 1'b1 < budget)) begin
              rk        <= rk + 1'b1;
              scan_addr <= '0;
              found     <= 1'b0;
            end else begin
              oaddr <= '0;
              state <= B_RD;
            end
          end
        end
        B_RD: state <= B_EMIT;
        B_EMIT: begin
          if (slot_free) begin
            if (oaddr == count - 1'b1) begin
              count <= '0;
              state <= B_LOAD;
            end else begin
              oaddr <= oaddr + 1'b1;
              state <= B_RD;
            end
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == B_EMIT && slot_free) begin
      decision_id   <= id_rd;
      audible       <= chosen[oaddr[IW-1:0]];
      virtualized   <= !chosen[oaddr[IW-1:0]] && loop_rd;
      voice_gain    <= gain_rd;
      low_pass_hz   <= lp_rd;
      reverb_send   <= rv_rd;
      priority_rank <= chosen[oaddr[IW-1:0]] ? rank_rd : 6'd0;
      last_decision <= (oaddr == count - 1'b1);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SOURCES))
    else $error("stored source count beyond capacity");

  a_pick_fresh: assert property (@(posedge clk) disable iff (rst)
    pick |-> !chosen[best_idx])
    else $error("selected a source that already holds a voice");

  a_rank_budget: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> (rk < budget))
    else $error("selection rank reached the voice budget");

endmodule

// File: hdl/audio_voice_priority_planner_unit.sv
// ----------------------------------------------------------------------------
// Audio voice priority planner
// Collects a scene of sound sources, ranks them and assigns voices.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    one sound source
//  out      output     out_valid / out_ready  one decision per stored source
//  cfg      input      cfg_we                 quality_level in cfg_wdata[1:0]
//
// The front end takes one source at a time; its sequencer includes a 16-step divider.
// After the last source the back end scans scores once per voice slot,
// up to min(budget, count) scans, then reads out and emits each decision in turn.
// Reset clears all control state; quality_level returns to 1.
// A stalled output holds the back end; the queue lets the front keep going until it is full.
module audio_voice_priority_planner_unit #(
  parameter int MAX_SOURCES = avpp_pkg::MaxSourcesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        source_id,
  input  logic [2:0]         source_kind,
  input  logic               is_critical,
  input  logic               is_looping,
  input  logic signed [15:0] base_gain,
  input  logic signed [15:0] occlusion,
  input  logic signed [23:0] distance,
  input  logic signed [15:0] importance,
  input  logic signed [15:0] reverb_zone_send,
  input  logic               last_source,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        decision_id,
  output logic               audible,
  output logic               virtualized,
  output logic [15:0]        voice_gain,
  output logic [14:0]        low_pass_hz,
  output logic [15:0]        reverb_send,
  output logic [5:0]         priority_rank,
  output logic               last_decision
);
  import avpp_pkg::*;

  logic [1:0] quality_level;
  logic       f_valid;
  logic       f_ready;
  rec_t       f_data;
  logic       b_valid;
  logic       b_ready;
  rec_t       b_data;

  // Quality register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quality_level <= 2'd1;
    end else if (cfg_we) begin
      quality_level <= cfg_wdata;
    end
  end

  avpp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .source_id, .source_kind, .is_critical,
    .is_looping, .base_gain, .occlusion, .distance, .importance,
    .reverb_zone_send, .last_source,
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  avpp_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  avpp_back #(.MAX_SOURCES(MAX_SOURCES)) u_back (
    .clk, .rst, .quality(quality_level),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid, .out_ready, .decision_id, .audible, .virtualized, .voice_gain,
    .low_pass_hz, .reverb_send, .priority_rank, .last_decision
  );

endmodule
